FILE: rtl/id3v2_apic_picture_extractor_defines.svh
// Assertion macros used by the checker file of the picture extractor.
`ifndef ID3V2_APIC_PICTURE_EXTRACTOR_DEFINES_SVH
`define ID3V2_APIC_PICTURE_EXTRACTOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ID3APIC_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ID3APIC_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/id3apic_pkg.sv
// Types, codes and constants of the embedded picture extractor.
package id3apic_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned MAX_W       = 25;
    localparam int unsigned TAG_SIZE_W  = 28;
    localparam int unsigned TAG_POS_W   = 29;
    localparam int unsigned FRAME_LEN_W = 32;

    localparam logic [MAX_W-1:0] MAX_PICTURE_RESET = 25'd2097152;

    localparam logic [KIND_W-1:0] KIND_PICTURE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUNCATED = 2'd2;

    localparam logic [31:0] APIC_ID = 32'h41504943;

    typedef struct packed {
        logic [BYTE_W-1:0] file_byte;
        logic              start_of_file;
        logic              end_of_file;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] result_kind;
        logic [BYTE_W-1:0] picture_byte;
        logic              is_last;
    } result_t;

    // Expected tag magic, one byte for each of the first three header positions.
    function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] m;
        case (idx)
            2'd0:    m = 8'h49;
            2'd1:    m = 8'h44;
            2'd2:    m = 8'h33;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/id3apic_core.sv
// Tag, frame and picture parser: one file byte per step, at most one result.
module id3apic_core
    import id3apic_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  item_t            item,
    input  logic [MAX_W-1:0] max_bytes,
    output result_t          result
);

    localparam logic [3:0] PH_TAG   = 4'd0;
    localparam logic [3:0] PH_FRAME = 4'd1;
    localparam logic [3:0] PH_SKIP  = 4'd2;
    localparam logic [3:0] PH_ENC   = 4'd3;
    localparam logic [3:0] PH_MIME  = 4'd4;
    localparam logic [3:0] PH_TYPE  = 4'd5;
    localparam logic [3:0] PH_DESC  = 4'd6;
    localparam logic [3:0] PH_PIC   = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;

    logic [3:0]             phase_reg, phase_next, phase_s;
    logic [3:0]             hbc_reg, hbc_next, hbc_s;
    logic [TAG_SIZE_W-1:0]  tsz_reg, tsz_next, tsz_s;
    logic [TAG_POS_W-1:0]   tpos_reg, tpos_next, tpos_s;
    logic [63:0]            shift_reg, shift_next, shift_s;
    logic [FRAME_LEN_W-1:0] fbl_reg, fbl_next, fbl_s;
    logic                   wide_reg, wide_next, wide_s;
    logic                   odd_reg, odd_next, odd_s;
    logic                   pz_reg, pz_next, pz_s;

    logic [BYTE_W-1:0]      b;
    logic [FRAME_LEN_W-1:0] fbl_dec;
    logic [TAG_POS_W-1:0]   tpos_inc;
    logic [FRAME_LEN_W-1:0] fsz;
    logic [33:0]            frame_next_pos;
    logic                   frame_fits;
    logic                   more_frames;
    logic [TAG_SIZE_W-1:0]  tsz_shifted;
    logic                   term;
    result_t                res;

    assign b = item.file_byte;

    // A start mark clears the parser before its byte is taken.
    assign phase_s = item.start_of_file ? PH_TAG : phase_reg;
    assign hbc_s   = item.start_of_file ? '0 : hbc_reg;
    assign tsz_s   = item.start_of_file ? '0 : tsz_reg;
    assign tpos_s  = item.start_of_file ? '0 : tpos_reg;
    assign shift_s = item.start_of_file ? '0 : shift_reg;
    assign fbl_s   = item.start_of_file ? '0 : fbl_reg;
    assign wide_s  = item.start_of_file ? 1'b0 : wide_reg;
    assign odd_s   = item.start_of_file ? 1'b0 : odd_reg;
    assign pz_s    = item.start_of_file ? 1'b0 : pz_reg;

    assign fbl_dec     = fbl_s - FRAME_LEN_W'(1);
    assign tpos_inc    = tpos_s + TAG_POS_W'(1);
    assign fsz         = shift_s[31:0];
    assign frame_next_pos = {5'b0, tpos_inc} + {2'b0, fsz};
    assign frame_fits  = frame_next_pos <= {6'b0, tsz_s};
    assign more_frames = {1'b0, tpos_s} <= {2'b0, tsz_s};
    assign tsz_shifted = {tsz_s[TAG_SIZE_W-8:0], b[6:0]};

    always_comb begin
        phase_next = phase_s;
        hbc_next   = hbc_s;
        tsz_next   = tsz_s;
        tpos_next  = tpos_s;
        shift_next = shift_s;
        fbl_next   = fbl_s;
        wide_next  = wide_s;
        odd_next   = odd_s;
        pz_next    = pz_s;
        term       = 1'b0;
        res        = '0;
        res.result_kind = KIND_NONE;

        case (phase_s)
            PH_TAG: begin
                if (hbc_s < 4'd3 && b != magic_byte(hbc_s[1:0])) begin
                    res.valid  = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    if (hbc_s >= 4'd6) begin
                        tsz_next = tsz_shifted;
                    end
                    if (hbc_s >= 4'd9) begin
                        hbc_next   = '0;
                        tpos_next  = TAG_POS_W'(10);
                        shift_next = '0;
                        if (tsz_shifted < TAG_SIZE_W'(10)) begin
                            res.valid  = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_FRAME;
                        end
                    end else begin
                        hbc_next = hbc_s + 4'd1;
                    end
                end
            end
            PH_FRAME: begin
                if (hbc_s < 4'd8) begin
                    shift_next = {shift_s[55:0], b};
                end
                tpos_next = tpos_inc;
                if (hbc_s >= 4'd9) begin
                    hbc_next  = '0;
                    fbl_next  = fsz;
                    tpos_next = frame_fits ? frame_next_pos[TAG_POS_W-1:0]
                                           : {1'b0, tsz_s} + TAG_POS_W'(10);
                    if (shift_s[63:32] == APIC_ID && fsz > FRAME_LEN_W'(10)) begin
                        phase_next = PH_ENC;
                    end else if (!frame_fits) begin
                        res.valid  = 1'b1;
                        phase_next = PH_DONE;
                    end else if (fsz == '0) begin
                        phase_next = PH_FRAME;
                        shift_next = '0;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end else begin
                    hbc_next = hbc_s + 4'd1;
                end
            end
            PH_SKIP, PH_ENC, PH_MIME, PH_TYPE, PH_DESC: begin
                fbl_next = fbl_dec;
                if (phase_s == PH_ENC) begin
                    wide_next  = b inside {8'd1, 8'd2};
                    phase_next = PH_MIME;
                end
                if (phase_s == PH_MIME && b == '0) begin
                    phase_next = PH_TYPE;
                end
                if (phase_s == PH_TYPE) begin
                    phase_next = PH_DESC;
                    odd_next   = 1'b0;
                    pz_next    = 1'b0;
                end
                if (phase_s == PH_DESC) begin
                    // UTF-16 descriptions end on an aligned zero pair.
                    if (!wide_s) begin
                        term = (b == '0);
                    end else if (!odd_s) begin
                        pz_next  = (b == '0);
                        odd_next = 1'b1;
                    end else begin
                        term     = pz_s && (b == '0);
                        odd_next = 1'b0;
                    end
                end
                if (term && fbl_dec != '0 && fbl_dec <= {7'b0, max_bytes}) begin
                    phase_next = PH_PIC;
                end else if (fbl_dec == '0) begin
                    // Frame consumed: next header or end of walk.
                    if (more_frames) begin
                        phase_next = PH_FRAME;
                        shift_next = '0;
                        hbc_next   = '0;
                    end else begin
                        phase_next = PH_DONE;
                        res.valid  = 1'b1;
                    end
                end else if (term) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_PIC: begin
                fbl_next         = fbl_dec;
                res.valid        = 1'b1;
                res.result_kind  = KIND_PICTURE;
                res.picture_byte = b;
                if (fbl_dec == '0) begin
                    res.is_last = 1'b1;
                    phase_next  = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (res.valid && res.result_kind == KIND_NONE) begin
            res.is_last = 1'b1;
        end

        if (item.end_of_file && phase_next != PH_DONE) begin
            res.result_kind  = res.valid ? KIND_TRUNCATED : KIND_NONE;
            res.picture_byte = '0;
            res.valid        = 1'b1;
            res.is_last      = 1'b1;
            phase_next       = PH_DONE;
        end
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG;
            hbc_reg   <= '0;
            tsz_reg   <= '0;
            tpos_reg  <= '0;
            shift_reg <= '0;
            fbl_reg   <= '0;
            wide_reg  <= 1'b0;
            odd_reg   <= 1'b0;
            pz_reg    <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            hbc_reg   <= hbc_next;
            tsz_reg   <= tsz_next;
            tpos_reg  <= tpos_next;
            shift_reg <= shift_next;
            fbl_reg   <= fbl_next;
            wide_reg  <= wide_next;
            odd_reg   <= odd_next;
            pz_reg    <= pz_next;
        end
    end

endmodule

FILE: rtl/id3v2_apic_picture_extractor.sv
// Embedded picture extractor: stream handshakes, input and result registers.
//
// Feed the audio file one byte per beat on the s_ channel: s_tdata carries
// the byte, s_tuser is 1 on the first byte of a file (restarts the parser),
// s_tlast is 1 on its final byte. The m_ channel returns the image bytes of
// the first usable APIC picture (m_tuser = 0, m_tlast on the final one), or
// one closing beat: m_tuser = 1 when the file has no usable picture, 2 when
// the file ends inside the picture. Further bytes of that file give nothing.
// cfg_we/cfg_wdata set the largest accepted picture size in bytes; write it
// only while the block is idle.
// Path: an input beat goes through the input register, the parse logic and the
// result register. Throughput: one byte per cycle while m_tready and s_tvalid
// stay high, set by the single parse step between the two registers.
// Reset: the size limit returns to 2097152, the parser to the tag header,
// both registers empty. When the receiver stalls, the result register
// holds, the input register takes at most one more beat, then s_tready drops.
module id3v2_apic_picture_extractor
    import id3apic_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] file_byte
    input  logic             s_tuser,   // [0] start_of_file
    input  logic             s_tlast,   // end_of_file
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] picture_byte
    output logic [1:0]       m_tuser,   // [1:0] result_kind
    output logic             m_tlast,   // is_last
    input  logic             cfg_we,
    input  logic [MAX_W-1:0] cfg_wdata
);

    logic              in_valid_reg, in_valid_next;
    item_t             in_item_reg;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [MAX_W-1:0]  max_reg;
    logic              advance;
    logic              s_accept;
    result_t           res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    id3apic_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .max_bytes (max_reg),
        .result    (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= MAX_PICTURE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= '{file_byte: s_tdata, start_of_file: s_tuser,
                             end_of_file: s_tlast};
        end
        if (advance && res.valid) begin
            out_kind_reg <= res.result_kind;
            out_byte_reg <= res.picture_byte;
            out_last_reg <= res.is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/id3apic_checker.sv
// Port-level checks of the picture extractor, bound to the top level.
`include "id3v2_apic_picture_extractor_defines.svh"

module id3apic_checker
    import id3apic_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    `ID3APIC_CHECK_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result after reset")

    `ID3APIC_CHECK(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

    `ID3APIC_CHECK(a_status_closes, aclk, aresetn, m_tvalid && m_tuser != KIND_PICTURE |-> m_tlast && m_tdata == '0, "status beat not final or data not zero")

    `ID3APIC_CHECK(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input blocked with empty output")

endmodule

bind id3v2_apic_picture_extractor id3apic_checker u_checker (.*);

FILE: tb/testbench.sv
// Self-checking stream testbench for the ID3v2 APIC picture extractor.
`timescale 1ns / 1ps

module testbench;
    import id3apic_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 80;

    localparam logic [MAX_W-1:0] PHASE_LIMITS [6] =
        '{25'd20, 25'd1, 25'd0, 25'h1FFFFFF, 25'd16777216, 25'd6};
    localparam logic [7:0] TAG_MAGIC [3] = '{8'h49, 8'h44, 8'h33};

    typedef enum logic [3:0] {
        TAG_HEADER, FRAME_HEADER, SKIP_FRAME, ENCODING, MIME_TYPE,
        PICTURE_TYPE, DESCRIPTION, PICTURE, FINISHED
    } parse_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        pic_byte;
        logic              last;
    } outcome_t;

    typedef struct packed {
        logic [7:0] b;
        logic       sof;
        logic       eof;
        logic       typed;
        logic       got;
        outcome_t   res;
    } row_t;

    localparam outcome_t NO_RESULT  = '{KIND_PICTURE, 8'h00, 1'b0};
    localparam outcome_t NO_PICTURE = '{KIND_NONE, 8'h00, 1'b1};

    // b, start, end, typed, result due, result
    localparam row_t DIRECTED_ROWS [20] = '{
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, NO_PICTURE},  // no start mark, bad first byte
        '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},   // ignored after the result
        '{8'h49, 1'b0, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{8'h49, 1'b1, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h44, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h51, 1'b0, 1'b0, 1'b1, 1'b1, NO_PICTURE},  // bad third magic byte
        '{8'h49, 1'b1, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h44, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h33, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h89, 1'b0, 1'b0, 1'b1, 1'b1, NO_PICTURE},  // tag size 9, top bits masked
        '{8'h49, 1'b1, 1'b1, 1'b1, 1'b1, NO_PICTURE},  // one-byte file
        '{8'h49, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h44, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h33, 1'b0, 1'b1, 1'b1, 1'b1, NO_PICTURE}   // file ends in the tag header
    };

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             s_tuser   = 1'b0;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic [MAX_W-1:0] cfg_wdata = '0;

    // parser mirror
    parse_phase_t          phase;
    logic [3:0]            hdr_count;
    logic [TAG_SIZE_W-1:0] tag_len;
    logic [TAG_POS_W-1:0]  tag_pos;
    logic [63:0]           hdr_shift;
    logic [31:0]           frame_left;
    logic [31:0]           pic_left;
    logic                  desc_utf16;
    logic                  desc_second;
    logic                  desc_zero_seen;
    logic [MAX_W-1:0]      picture_limit = MAX_PICTURE_RESET;

    outcome_t   due_results [$];
    logic [7:0] file_q [$];
    logic [7:0] tag_body [$];
    int         sent_items;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         errors       = 0;
    int         stall_cycles = 0;
    int         hold_left    = 0;
    logic       hold_toggle = 1'b0;
    logic       hold_ack    = 1'b0;

    id3v2_apic_picture_extractor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic void restart_parser();
        phase = TAG_HEADER;
        hdr_count = '0;
        tag_len = '0;
        tag_pos = '0;
        hdr_shift = '0;
        frame_left = '0;
        pic_left = '0;
        desc_utf16 = 1'b0;
        desc_second = 1'b0;
        desc_zero_seen = 1'b0;
    endfunction

    // Frame consumed: read the next header if one still fits, else end the walk.
    function automatic bit close_frame();
        if (tag_pos <= tag_len) begin
            phase = FRAME_HEADER;
            hdr_shift = '0;
            hdr_count = '0;
            return 1'b0;
        end
        phase = FINISHED;
        return 1'b1;
    endfunction

    function automatic bit open_frame();
        logic [31:0] id;
        logic [31:0] fsz;
        logic [63:0] tag_end;
        logic [63:0] nxt;
        bit          fits;
        id = hdr_shift[63:32];
        fsz = hdr_shift[31:0];
        tag_end = 64'(tag_len) + 64'd10;
        nxt = 64'(tag_pos) + 64'(fsz);
        fits = (nxt + 64'd10) <= tag_end;
        tag_pos = fits ? nxt[TAG_POS_W-1:0] : tag_end[TAG_POS_W-1:0];
        frame_left = fsz;
        if (id == APIC_ID && fsz > 32'd10) begin
            phase = ENCODING;
            return 1'b0;
        end
        if (!fits) begin
            phase = FINISHED;
            return 1'b1;
        end
        if (fsz == 32'd0)
            return close_frame();
        phase = SKIP_FRAME;
        return 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic sof, input logic eof,
                              output bit got, output outcome_t res);
        bit term;
        got = 1'b0;
        term = 1'b0;
        res = '{KIND_NONE, 8'h00, 1'b0};
        if (sof)
            restart_parser();
        case (phase)
            TAG_HEADER: begin
                if (hdr_count < 4'd3 && b != TAG_MAGIC[hdr_count[1:0]]) begin
                    got = 1'b1;
                    phase = FINISHED;
                end else begin
                    if (hdr_count >= 4'd6)
                        tag_len = {tag_len[20:0], b[6:0]};
                    if (hdr_count >= 4'd9) begin
                        hdr_count = '0;
                        tag_pos = TAG_POS_W'(10);
                        hdr_shift = '0;
                        if (tag_len < TAG_SIZE_W'(10)) begin
                            got = 1'b1;
                            phase = FINISHED;
                        end else begin
                            phase = FRAME_HEADER;
                        end
                    end else begin
                        hdr_count++;
                    end
                end
            end
            FRAME_HEADER: begin
                if (hdr_count < 4'd8)
                    hdr_shift = {hdr_shift[55:0], b};
                tag_pos++;
                if (hdr_count >= 4'd9) begin
                    hdr_count = '0;
                    got = open_frame();
                end else begin
                    hdr_count++;
                end
            end
            SKIP_FRAME: begin
                frame_left--;
                if (frame_left == 32'd0)
                    got = close_frame();
            end
            ENCODING: begin
                frame_left--;
                desc_utf16 = (b == 8'd1 || b == 8'd2);
                phase = MIME_TYPE;
                if (frame_left == 32'd0)
                    got = close_frame();
            end
            MIME_TYPE: begin
                frame_left--;
                if (b == 8'd0)
                    phase = PICTURE_TYPE;
                if (frame_left == 32'd0)
                    got = close_frame();
            end
            PICTURE_TYPE: begin
                frame_left--;
                phase = DESCRIPTION;
                desc_second = 1'b0;
                desc_zero_seen = 1'b0;
                if (frame_left == 32'd0)
                    got = close_frame();
            end
            DESCRIPTION: begin
                frame_left--;
                // wide text ends only on a zero pair aligned to two bytes
                if (!desc_utf16) begin
                    term = (b == 8'd0);
                end else if (!desc_second) begin
                    desc_zero_seen = (b == 8'd0);
                    desc_second = 1'b1;
                end else begin
                    term = desc_zero_seen && b == 8'd0;
                    desc_second = 1'b0;
                end
                if (term && frame_left != 32'd0 && frame_left <= 32'(picture_limit)) begin
                    pic_left = frame_left;
                    phase = PICTURE;
                end else if (frame_left == 32'd0) begin
                    got = close_frame();
                end else if (term) begin
                    phase = SKIP_FRAME;
                end
            end
            PICTURE: begin
                pic_left--;
                got = 1'b1;
                res.kind = KIND_PICTURE;
                res.pic_byte = b;
                if (pic_left == 32'd0) begin
                    res.last = 1'b1;
                    phase = FINISHED;
                end
            end
            default: ;
        endcase
        if (got && res.kind == KIND_NONE)
            res.last = 1'b1;
        if (eof && phase != FINISHED) begin
            if (got) begin
                res.kind = KIND_TRUNCATED;
                res.pic_byte = 8'h00;
            end else begin
                got = 1'b1;
                res.kind = KIND_NONE;
            end
            res.last = 1'b1;
            phase = FINISHED;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic sof, input logic eof,
                             input bit typed, input bit typed_got, input outcome_t typed_res);
        bit       got;
        outcome_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sof;
        s_tlast <= eof;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, sof, eof, got, res);
        if (typed) begin
            got = typed_got;
            res = typed_res;
        end
        if (got)
            due_results.push_back(res);
        sent_items++;
    endtask

    task automatic write_picture_limit(input logic [MAX_W-1:0] value);
        while (due_results.size() != 0)
            @(posedge aclk);
        // let a beat that gives no result clear the pipeline
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        picture_limit = value;
    endtask

    function automatic void add_frame_header(input logic [31:0] id, input logic [31:0] fsz);
        for (int i = 3; i >= 0; i--)
            tag_body.push_back(id[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            tag_body.push_back(fsz[8*i +: 8]);
        repeat (2) tag_body.push_back(8'($urandom));
    endfunction

    function automatic void add_apic_frame();
        logic [7:0]  payload [$];
        logic [7:0]  enc;
        logic [31:0] fsz;
        int          pick;
        int          pic_len;
        enc = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        payload.push_back(enc);
        repeat ($urandom_range(3)) payload.push_back(8'($urandom_range(1, 255)));
        payload.push_back(8'h00);
        // type 0 must not be taken as a terminator
        payload.push_back(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
        if (enc == 8'd1 || enc == 8'd2) begin
            // a lone zero, or zeros split across two pairs, must not end the text
            repeat ($urandom_range(3)) begin
                pick = $urandom_range(3);
                payload.push_back(pick == 1 ? 8'h00 : 8'($urandom_range(1, 255)));
                payload.push_back(pick == 2 ? 8'h00 : 8'($urandom_range(1, 255)));
            end
            payload.push_back(8'h00);
            payload.push_back(8'h00);
        end else begin
            repeat ($urandom_range(3)) payload.push_back(8'($urandom_range(1, 255)));
            payload.push_back(8'h00);
        end
        pic_len = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(12);
        repeat (pic_len) payload.push_back(8'($urandom));
        fsz = payload.size();
        pick = $urandom_range(19);
        if (pick < 3)
            fsz = $urandom_range(1, payload.size() - 1);
        else if (pick == 3)
            fsz = $urandom_range(10);
        else if (pick == 4)
            fsz = fsz + $urandom_range(1, 3);
        add_frame_header(APIC_ID, fsz);
        foreach (payload[i])
            tag_body.push_back(payload[i]);
    endfunction

    function automatic void add_other_frame();
        logic [31:0] id;
        logic [31:0] fsz;
        int          len;
        for (int i = 0; i < 4; i++)
            id[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5A));
        len = $urandom_range(6);
        fsz = ($urandom_range(9) == 0) ? 32'($urandom) : 32'(len);
        add_frame_header(id, fsz);
        repeat (len) tag_body.push_back(8'($urandom));
    endfunction

    function automatic void build_tagged_file();
        int tsize;
        int pick;
        int keep;
        tag_body.delete();
        file_q.delete();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(99) < 55)
                add_apic_frame();
            else
                add_other_frame();
        end
        repeat ($urandom_range(3)) tag_body.push_back(8'h00);
        tsize = tag_body.size();
        pick = $urandom_range(19);
        if (pick < 3)
            tsize = $urandom_range(tsize);
        else if (pick == 3)
            tsize = $urandom_range(9);
        file_q.push_back(8'h49);
        file_q.push_back(8'h44);
        file_q.push_back(8'h33);
        repeat (3) file_q.push_back(8'($urandom));
        // synchsafe size; the top bit of each byte must be ignored
        for (int i = 3; i >= 0; i--)
            file_q.push_back({1'($urandom_range(4) == 0), 7'(tsize >> (7 * i))});
        foreach (tag_body[i])
            file_q.push_back(tag_body[i]);
        repeat ($urandom_range(4)) file_q.push_back(8'($urandom));
        if ($urandom_range(6) == 0) begin
            keep = $urandom_range(1, file_q.size());
            while (file_q.size() > keep)
                void'(file_q.pop_back());
        end
    endfunction

    function automatic void build_noise_file();
        file_q.delete();
        if ($urandom_range(1) == 1) begin
            file_q.push_back(8'h49);
            if ($urandom_range(1) == 1)
                file_q.push_back(8'h44);
        end
        repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom));
    endfunction

    task automatic send_file();
        bit sof_mark;
        bit eof_mark;
        sof_mark = ($urandom_range(19) != 0);
        eof_mark = ($urandom_range(19) != 0);
        foreach (file_q[i])
            send_beat(file_q[i], sof_mark && i == 0, eof_mark && i == file_q.size() - 1,
                      1'b0, 1'b0, NO_RESULT);
    endtask

    // result side: check each beat, then pick the next ready
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result kind", m_tuser, 0);
            end else begin
                want = due_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata !== want.pic_byte)
                    report_mismatch("picture_byte", m_tdata, want.pic_byte);
                if (m_tlast !== want.last)
                    report_mismatch("is_last", m_tlast, want.last);
            end
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_toggle) begin
            hold_ack <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int pick;
        sent_items = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        restart_parser();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i])
            send_beat(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].sof, DIRECTED_ROWS[i].eof,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].got, DIRECTED_ROWS[i].res);
        s_tvalid <= 1'b0;

        for (int p = 0; p < 6; p++) begin
            write_picture_limit(p == 5 ? 25'($urandom_range(2, 30)) : PHASE_LIMITS[p]);
            tx_idle_pct = (p < 2) ? 34 : (p < 4) ? 86 : 0;
            rx_idle_pct = (p < 2) ? 86 : (p < 4) ? 34 : 0;
            // stall the result side while the sender keeps pushing
            if (p == 4)
                hold_toggle <= ~hold_toggle;
            sent_items = 0;
            while (sent_items < PHASE_ITEMS) begin
                pick = $urandom_range(19);
                if (pick < 3) begin
                    build_noise_file();
                end else begin
                    build_tagged_file();
                    if (pick < 6)
                        file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
                end
                send_file();
            end
            s_tvalid <= 1'b0;
        end

        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
